// ===== src/vplmf_pkg.sv =====
// Package for the velocity PI loop with mean filter.
// Holds field widths, fixed-point constants, register reset values and the
// shared types between the controller, the datapath and the register file.
package vplmf_pkg;

    // Window length default; the top level carries it as a parameter.
    localparam int WINDOW_LEN_DEF = 10;

    // Input and output field widths.
    localparam int SPEED_W    = 15;
    localparam int CHANNEL_W  = 11;
    localparam int DRIVE_W    = 16;
    localparam int IN_TDATA_W = 48;
    localparam int OUT_TDATA_W = 16;

    // Register port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int GAIN_W     = 24;
    localparam int ILIM_UP_W  = 23;
    localparam int ILIM_DN_W  = 24;
    localparam int DLIM_UP_W  = 15;
    localparam int DLIM_DN_W  = 16;

    // Internal arithmetic widths.
    localparam int PAIR_W     = 16;   // left + right
    localparam int THR_W      = 12;   // channel minus center
    localparam int INT_W      = 32;   // integral, Q8
    localparam int INT_SUM_W  = 34;   // integral before clamping
    localparam int FE_W       = 25;   // filtered error, Q8
    localparam int DIF_W      = 26;   // error minus mean, Q8
    localparam int MEAN_W     = 16;
    localparam int QUO_W      = 16;
    localparam int MUL_A_W    = 33;
    localparam int MUL_B_W    = 25;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = 60;

    // Fixed-point constants.
    localparam int Q8_SHIFT        = 8;
    localparam int BLEND_FRAC      = 16;
    localparam int DRIVE_FRAC      = 24;
    localparam int BLEND_OLD       = 45875;
    localparam int BLEND_NEW       = 19661;
    localparam int THROTTLE_CENTER = 1000;

    // Register reset values.
    localparam logic [GAIN_W-1:0]           GAIN_P_RST = 24'd39322;
    localparam logic [GAIN_W-1:0]           GAIN_I_RST = 24'd393;
    localparam logic [GAIN_W-1:0]           GAIN_D_RST = 24'd0;
    localparam logic [ILIM_UP_W-1:0]        ILIM_UP_RST = 23'd100000;
    localparam logic signed [ILIM_DN_W-1:0] ILIM_DN_RST = -24'sd100000;
    localparam logic [DLIM_UP_W-1:0]        DLIM_UP_RST = 15'd1800;
    localparam logic signed [DLIM_DN_W-1:0] DLIM_DN_RST = -16'sd1800;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P      = 3'd0,
        CFG_GAIN_I      = 3'd1,
        CFG_GAIN_D      = 3'd2,
        CFG_INT_UPPER   = 3'd3,
        CFG_INT_LOWER   = 3'd4,
        CFG_DRIVE_UPPER = 3'd5,
        CFG_DRIVE_LOWER = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0]           gain_p;
        logic [GAIN_W-1:0]           gain_i;
        logic [GAIN_W-1:0]           gain_d;
        logic [ILIM_UP_W-1:0]        integral_upper;
        logic signed [ILIM_DN_W-1:0] integral_lower;
        logic [DLIM_UP_W-1:0]        drive_upper;
        logic signed [DLIM_DN_W-1:0] drive_lower;
    } t_cfg;

    typedef struct packed {
        logic signed [SPEED_W-1:0] left_speed;
        logic signed [SPEED_W-1:0] right_speed;
        logic                      remote_active;
        logic [CHANNEL_W-1:0]      throttle_channel;
        logic                      run_enable;
    } t_in_item;

    typedef enum logic [3:0] {
        S_IDLE, S_WIN, S_CLAMP, S_RCP, S_QN, S_CORR, S_BNEW,
        S_BSUM, S_BDIV, S_DIF, S_MI, S_MD, S_ACC, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        MUL_NONE, MUL_RCP, MUL_QN, MUL_FE_OLD, MUL_MEAN_NEW, MUL_GP, MUL_GI, MUL_GD
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_ADD_SHL
    } t_acc_op;

    typedef struct packed {
        logic     capture;
        logic     win_step;
        logic     clamp_step;
        logic     q_load;
        logic     mean_load;
        logic     fe_load;
        logic     dif_load;
        logic     out_load;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
    } t_dp_cmd;

endpackage

// ===== src/vplmf_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module vplmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/vplmf_cfg.sv =====
// Configuration register file of the velocity loop.
// Depends on vplmf_pkg for the register indexes, widths and reset values.
module vplmf_cfg
    import vplmf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);
    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_P:      n_cfg.gain_p         = i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:      n_cfg.gain_i         = i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:      n_cfg.gain_d         = i_cfg_data[GAIN_W-1:0];
                CFG_INT_UPPER:   n_cfg.integral_upper = i_cfg_data[ILIM_UP_W-1:0];
                CFG_INT_LOWER:   n_cfg.integral_lower = $signed(i_cfg_data[ILIM_DN_W-1:0]);
                CFG_DRIVE_UPPER: n_cfg.drive_upper    = i_cfg_data[DLIM_UP_W-1:0];
                CFG_DRIVE_LOWER: n_cfg.drive_lower    = $signed(i_cfg_data[DLIM_DN_W-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p         <= GAIN_P_RST;
            r_cfg.gain_i         <= GAIN_I_RST;
            r_cfg.gain_d         <= GAIN_D_RST;
            r_cfg.integral_upper <= ILIM_UP_RST;
            r_cfg.integral_lower <= ILIM_DN_RST;
            r_cfg.drive_upper    <= DLIM_UP_RST;
            r_cfg.drive_lower    <= DLIM_DN_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // The port is always ready, so writes are never stalled.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;
endmodule

// ===== src/vplmf_ctrl.sv =====
// Sequencer of the velocity loop: steps the datapath through one tick and
// owns the stream handshakes. Depends on vplmf_pkg.
module vplmf_ctrl
    import vplmf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);
    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_WIN;
            S_WIN:   n_state = S_CLAMP;
            S_CLAMP: n_state = S_RCP;
            S_RCP:   n_state = S_QN;
            S_QN:    n_state = S_CORR;
            S_CORR:  n_state = S_BNEW;
            S_BNEW:  n_state = S_BSUM;
            S_BSUM:  n_state = S_BDIV;
            S_BDIV:  n_state = S_DIF;
            S_DIF:   n_state = S_MI;
            S_MI:    n_state = S_MD;
            S_MD:    n_state = S_ACC;
            S_ACC:   n_state = S_DONE;
            S_DONE:  if (slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_NONE;
        o_cmd.acc_op  = ACC_HOLD;
        o_in_ready    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_WIN:   o_cmd.win_step = 1'b1;
            S_CLAMP: o_cmd.clamp_step = 1'b1;
            S_RCP:   o_cmd.mul_sel = MUL_RCP;
            S_QN: begin
                o_cmd.mul_sel = MUL_QN;
                o_cmd.q_load  = 1'b1;
            end
            S_CORR: begin
                o_cmd.mean_load = 1'b1;
                o_cmd.mul_sel   = MUL_FE_OLD;
            end
            S_BNEW: begin
                o_cmd.mul_sel = MUL_MEAN_NEW;
                o_cmd.acc_op  = ACC_LOAD;
            end
            S_BSUM:  o_cmd.acc_op = ACC_ADD_SHL;
            S_BDIV:  o_cmd.fe_load = 1'b1;
            S_DIF: begin
                o_cmd.dif_load = 1'b1;
                o_cmd.mul_sel  = MUL_GP;
            end
            S_MI: begin
                o_cmd.mul_sel = MUL_GI;
                o_cmd.acc_op  = ACC_LOAD;
            end
            S_MD: begin
                o_cmd.mul_sel = MUL_GD;
                o_cmd.acc_op  = ACC_ADD;
            end
            S_ACC:   o_cmd.acc_op = ACC_ADD;
            S_DONE:  o_cmd.out_load = slot_free;
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

// ===== src/vplmf_dp.sv =====
// Datapath of the velocity loop: speed window in RAM, integral, window mean by
// reciprocal multiply, blended error and drive sum on one shared multiplier.
// Depends on vplmf_pkg and vplmf_ram.
module vplmf_dp
    import vplmf_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    input  t_cfg                      i_cfg,
    input  t_in_item                  i_item,
    output logic signed [DRIVE_W-1:0] o_drive
);
    localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W = PAIR_W + $clog2(WINDOW_LEN);
    // Truncated reciprocal: the estimate is at most one below the quotient.
    localparam int RECIP = (1 << SUM_W) / WINDOW_LEN;

    // Item registers.
    logic signed [PAIR_W-1:0]    r_new;
    logic signed [THR_W-1:0]     r_thr;
    logic                        r_run;

    // Loop state.
    logic [PTR_W-1:0]            r_ptr;
    logic [CNT_W-1:0]            r_fill;
    logic signed [SUM_W-1:0]     r_wsum;
    logic signed [INT_W-1:0]     r_integral;
    logic signed [FE_W-1:0]      r_fe;

    // Working registers.
    logic signed [INT_SUM_W-1:0] r_int_sum;
    logic [SUM_W-1:0]            r_abs;
    logic                        r_neg;
    logic signed [PROD_W-1:0]    r_prod;
    logic [QUO_W-1:0]            r_q;
    logic signed [MEAN_W-1:0]    r_mean;
    logic signed [ACC_W-1:0]     r_acc;
    logic signed [DIF_W-1:0]     r_dif;
    logic signed [DRIVE_W-1:0]   r_drive;

    logic [PAIR_W-1:0]           ram_rdata;
    logic signed [PAIR_W-1:0]    win_old;
    logic signed [SUM_W-1:0]     n_wsum;
    logic signed [INT_SUM_W-1:0] int_up;
    logic signed [INT_SUM_W-1:0] int_dn;
    logic signed [INT_W-1:0]     n_integral;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]    mul_p;
    logic [QUO_W-1:0]            q_est;
    logic [SUM_W:0]              rem;
    logic [QUO_W-1:0]            q_fix;
    logic [QUO_W:0]              q_ext;
    logic signed [ACC_W-1:0]     fe_full;
    logic signed [ACC_W-1:0]     drv_up;
    logic signed [ACC_W-1:0]     drv_dn;
    logic signed [ACC_W-1:0]     drv_biased;
    logic signed [DRIVE_W-1:0]   n_drive;

    vplmf_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (WINDOW_LEN)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (i_cmd.win_step),
        .i_waddr (r_ptr),
        .i_wdata (r_new),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    // Until the window has filled once, the leaving sample is a reset zero.
    assign win_old = (r_fill == CNT_W'(WINDOW_LEN)) ? $signed(ram_rdata) : '0;
    assign n_wsum  = r_wsum - SUM_W'(win_old) + SUM_W'(r_new);

    assign int_up = $signed({3'b000, i_cfg.integral_upper, 8'h00});
    assign int_dn = INT_SUM_W'($signed({i_cfg.integral_lower, 8'h00}));

    always_comb begin
        if (!r_run) begin
            n_integral = '0;
        end else if (r_int_sum >= int_up) begin
            n_integral = $signed(int_up[INT_W-1:0]);
        end else if (r_int_sum <= int_dn) begin
            n_integral = $signed(int_dn[INT_W-1:0]);
        end else begin
            n_integral = $signed(r_int_sum[INT_W-1:0]);
        end
    end

    assign q_est = r_prod[SUM_W +: QUO_W];

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_RCP: begin
                mul_a = MUL_A_W'($signed({1'b0, r_abs}));
                mul_b = MUL_B_W'(RECIP);
            end
            MUL_QN: begin
                mul_a = MUL_A_W'($signed({1'b0, q_est}));
                mul_b = MUL_B_W'(WINDOW_LEN);
            end
            MUL_FE_OLD: begin
                mul_a = MUL_A_W'(r_fe);
                mul_b = MUL_B_W'(BLEND_OLD);
            end
            MUL_MEAN_NEW: begin
                mul_a = MUL_A_W'(r_mean);
                mul_b = MUL_B_W'(BLEND_NEW);
            end
            MUL_GP: begin
                mul_a = MUL_A_W'(r_fe);
                mul_b = $signed({1'b0, i_cfg.gain_p});
            end
            MUL_GI: begin
                mul_a = MUL_A_W'(r_integral);
                mul_b = $signed({1'b0, i_cfg.gain_i});
            end
            MUL_GD: begin
                mul_a = MUL_A_W'(r_dif);
                mul_b = $signed({1'b0, i_cfg.gain_d});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // r_prod holds q_est * WINDOW_LEN while the remainder is checked.
    assign rem   = {1'b0, r_abs} - r_prod[SUM_W:0];
    assign q_fix = (rem >= (SUM_W + 1)'(WINDOW_LEN)) ? r_q + 1'b1 : r_q;
    assign q_ext = r_neg ? ((QUO_W + 1)'(0) - {1'b0, q_fix}) : {1'b0, q_fix};

    // Division by 2^16 rounds toward zero.
    assign fe_full = (r_acc + (r_acc[ACC_W-1] ? ACC_W'((1 << BLEND_FRAC) - 1) : '0))
                     >>> BLEND_FRAC;

    assign drv_up     = ACC_W'($signed({1'b0, i_cfg.drive_upper})) <<< DRIVE_FRAC;
    assign drv_dn     = ACC_W'(i_cfg.drive_lower) <<< DRIVE_FRAC;
    assign drv_biased = r_acc + (r_acc[ACC_W-1] ? ACC_W'((1 << DRIVE_FRAC) - 1) : '0);

    always_comb begin
        if (r_acc >= drv_up) begin
            n_drive = $signed({1'b0, i_cfg.drive_upper});
        end else if (r_acc <= drv_dn) begin
            n_drive = i_cfg.drive_lower;
        end else begin
            n_drive = $signed(drv_biased[DRIVE_FRAC +: DRIVE_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr      <= '0;
            r_fill     <= '0;
            r_wsum     <= '0;
            r_integral <= '0;
            r_fe       <= '0;
        end else begin
            if (i_cmd.win_step) begin
                r_wsum <= n_wsum;
                r_ptr  <= (r_ptr == PTR_W'(WINDOW_LEN - 1)) ? '0 : r_ptr + 1'b1;
                if (r_fill != CNT_W'(WINDOW_LEN)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (i_cmd.clamp_step) begin
                r_integral <= n_integral;
            end
            if (i_cmd.fe_load) begin
                r_fe <= $signed(fe_full[FE_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (i_cmd.capture) begin
            r_new <= $signed({i_item.left_speed[SPEED_W-1], i_item.left_speed})
                   + $signed({i_item.right_speed[SPEED_W-1], i_item.right_speed});
            r_thr <= i_item.remote_active
                   ? ($signed({1'b0, i_item.throttle_channel}) - THR_W'(THROTTLE_CENTER))
                   : '0;
            r_run <= i_item.run_enable;
        end
        if (i_cmd.win_step) begin
            // The integral gains the filtered error of the previous tick.
            r_int_sum <= INT_SUM_W'(r_integral) + INT_SUM_W'(r_fe)
                       + (INT_SUM_W'(r_thr) <<< Q8_SHIFT);
        end
        if (i_cmd.clamp_step) begin
            r_neg <= r_wsum[SUM_W-1];
            r_abs <= r_wsum[SUM_W-1] ? SUM_W'(-r_wsum) : SUM_W'(r_wsum);
        end
        if (i_cmd.q_load) begin
            r_q <= q_est;
        end
        if (i_cmd.mean_load) begin
            r_mean <= $signed(q_ext[MEAN_W-1:0]);
        end
        case (i_cmd.acc_op)
            ACC_LOAD:    r_acc <= ACC_W'(r_prod);
            ACC_ADD:     r_acc <= r_acc + ACC_W'(r_prod);
            ACC_ADD_SHL: r_acc <= r_acc + (ACC_W'(r_prod) <<< Q8_SHIFT);
            default: ;
        endcase
        if (i_cmd.dif_load) begin
            r_dif <= DIF_W'(r_fe) - (DIF_W'(r_mean) <<< Q8_SHIFT);
        end
        if (i_cmd.out_load) begin
            r_drive <= n_drive;
        end
    end

    assign o_drive = r_drive;
endmodule

// ===== src/velocity_pi_loop_with_mean_filter_unit.sv =====
// Velocity PI loop with a moving-average speed filter, top level.
// Depends on vplmf_pkg, vplmf_cfg, vplmf_ctrl, vplmf_dp and vplmf_ram.
//
// Usage:
//   The slave stream takes one control tick per transaction: both wheel speeds,
//   the remote throttle with its enable, and the run enable. The master stream
//   returns one signed drive value per tick.
//   The register port writes gains and clamps by index. The user must write it
//   only while the loop is idle; the block itself does not enforce this.
// Sequencing:
//   A result is registered out of the last sequencer state, S_DONE. The tick is
//   worked through by a 14-state sequencer sharing one 33x25 multiplier, so a
//   new tick is taken only once the sequencer is back in S_IDLE.
//   The output register holds a finished drive value, so the next tick is
//   accepted while that value waits for the receiver.
// Reset and stall:
//   Synchronous active-low reset restores the register defaults and clears the
//   speed window, integral and filtered error; the window is cleared through a
//   fill count, so no clearing pass is needed. If the receiver stalls, the next
//   tick is finished and held in the last sequencer step until the output
//   register frees.
module velocity_pi_loop_with_mean_filter_unit
    import vplmf_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // [14:0] left_speed, [29:15] right_speed, [30] remote_active,
    // [41:31] throttle_channel, [42] run_enable, [47:43] zero
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [15:0] drive
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);
    t_cfg                      cfg;
    t_dp_cmd                   cmd;
    t_in_item                  item;
    logic signed [DRIVE_W-1:0] drive;

    assign item.left_speed       = $signed(i_s_tdata[14:0]);
    assign item.right_speed      = $signed(i_s_tdata[29:15]);
    assign item.remote_active    = i_s_tdata[30];
    assign item.throttle_channel = i_s_tdata[41:31];
    assign item.run_enable       = i_s_tdata[42];

    vplmf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    vplmf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_cmd       (cmd)
    );

    vplmf_dp #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_cfg   (cfg),
        .i_item  (item),
        .o_drive (drive)
    );

    assign o_m_tdata = drive;
endmodule

// ===== src/vplmf_checker.sv =====
// Port-level checker for the velocity loop, bound to the top level.
// Depends on vplmf_pkg for port widths.
module vplmf_checker
    import vplmf_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic [IN_TDATA_W-1:0]  i_s_tdata,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata,
    input logic                   i_cfg_valid,
    input logic                   o_cfg_ready,
    input logic [CFG_IDX_W-1:0]   i_cfg_index,
    input logic [CFG_DATA_W-1:0]  i_cfg_data
);
    // Reset leaves no stale result on the output.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // One tick is worked on at a time: the input closes after a transaction.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while busy");

    // A new result is only loaded while the sequencer is busy with a tick.
    a_result_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !$past(o_s_tready))
        else $error("result appeared while idle");
endmodule

bind velocity_pi_loop_with_mean_filter_unit vplmf_checker u_vplmf_checker (.*);
